### sv/arpc_pkg.sv
// arpc_pkg: shared types, codes and sizes for the arp cache and responder
// no dependencies; imported by arpc_front, arpc_back and arp_cache_responder
`timescale 1ns / 1ps

package arpc_pkg;

  // default number of table entries
  localparam int ARPC_TABLE_ENTRIES = 16;

  // field widths
  localparam int ARPC_IP_W   = 32;
  localparam int ARPC_MAC_W  = 48;
  localparam int ARPC_OPER_W = 16;

  // input opcodes
  localparam logic OPC_PACKET = 1'b0;
  localparam logic OPC_LOOKUP = 1'b1;

  // arp operation field values
  localparam logic [ARPC_OPER_W-1:0] OPER_REQUEST = 16'd1;
  localparam logic [ARPC_OPER_W-1:0] OPER_REPLY   = 16'd2;

  // result kinds
  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_REPLY    = 3'd1,
    KIND_RESOLVED = 3'd2,
    KIND_HIT      = 3'd3,
    KIND_PENDING  = 3'd4,
    KIND_QUERY    = 3'd5,
    KIND_FULL     = 3'd6
  } arpc_kind_t;

  // work class decided by the front end
  typedef enum logic [1:0] {
    CLS_NONE      = 2'd0,
    CLS_REPLY_NOW = 2'd1,
    CLS_ARP_REPLY = 2'd2,
    CLS_LOOKUP    = 2'd3
  } arpc_cls_t;

  // one classified transaction as it sits in the queue
  typedef struct packed {
    arpc_cls_t               cls;
    logic [ARPC_IP_W-1:0]    ip;
    logic [ARPC_MAC_W-1:0]   mac;
  } arpc_item_t;

  // queue handshake from front to back
  typedef struct packed {
    logic       vld;
    arpc_item_t item;
  } arpc_queue_t;

endpackage

### sv/arpc_front.sv
// arpc_front: own_ip register, transaction accept, classification and two-entry queue
// depends on arpc_pkg
`timescale 1ns / 1ps

module arpc_front
  import arpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ARPC_IP_W-1:0]    cfg_data,
  // command side
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_opcode,
  input  logic [ARPC_OPER_W-1:0]  in_arp_operation,
  input  logic [ARPC_IP_W-1:0]    in_sender_ip,
  input  logic [ARPC_MAC_W-1:0]   in_sender_mac,
  input  logic [ARPC_IP_W-1:0]    in_target_ip,
  input  logic [ARPC_IP_W-1:0]    in_lookup_ip,
  // queue to back end
  output arpc_queue_t             q_out,
  input  logic                    q_pop
);

  logic [ARPC_IP_W-1:0] own_ip_r;
  arpc_item_t           q_mem_r [2];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           q_cnt_r;
  logic                 push;
  arpc_item_t           cls_item;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_ip_r <= cfg_data;
    end
  end

  // classify the incoming transaction
  always_comb begin
    cls_item.cls = CLS_NONE;
    cls_item.ip  = '0;
    cls_item.mac = '0;
    if (in_opcode == OPC_LOOKUP) begin
      cls_item.cls = CLS_LOOKUP;
      cls_item.ip  = in_lookup_ip;
    end else if (in_arp_operation == OPER_REQUEST) begin
      if (in_target_ip == own_ip_r) begin
        cls_item.cls = CLS_REPLY_NOW;
        cls_item.ip  = in_sender_ip;
        cls_item.mac = in_sender_mac;
      end
    end else if (in_arp_operation == OPER_REPLY) begin
      cls_item.cls = CLS_ARP_REPLY;
      cls_item.ip  = in_sender_ip;
      cls_item.mac = in_sender_mac;
    end
  end

  // accept while the queue has room
  assign busy = (q_cnt_r == 2'd2);
  assign push = start && !busy;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  assign q_out.vld  = (q_cnt_r != 2'd0);
  assign q_out.item = q_mem_r[rd_ptr_r];

endmodule

### sv/arpc_back.sv
// arpc_back: table memory, sequential entry scan and result register
// depends on arpc_pkg; fed by arpc_front through the queue
`timescale 1ns / 1ps

module arpc_back
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  arpc_queue_t             q_in,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [2:0]              out_result_kind,
  output logic [ARPC_IP_W-1:0]    out_peer_ip,
  output logic [ARPC_MAC_W-1:0]   out_peer_mac
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } back_state_t;

  // control state
  back_state_t              state_r, state_nxt;
  logic [CW-1:0]            issue_r, issue_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic                     hit_seen_r, hit_seen_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [TABLE_ENTRIES-1:0] resolved_r;
  arpc_item_t               cur_r, cur_nxt;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  arpc_kind_t               out_kind_r, out_kind_nxt;
  logic [ARPC_IP_W-1:0]     out_ip_r, out_ip_nxt;
  logic [ARPC_MAC_W-1:0]    out_mac_r, out_mac_nxt;

  // table memories
  logic [ARPC_IP_W-1:0]     ip_mem  [TABLE_ENTRIES];
  logic [ARPC_MAC_W-1:0]    mac_mem [TABLE_ENTRIES];
  logic [ARPC_IP_W-1:0]     rd_ip_r;
  logic [ARPC_MAC_W-1:0]    rd_mac_r;

  // memory and flag controls
  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic                     ip_we;
  logic [IW-1:0]            ip_waddr;
  logic                     mac_we;
  logic [IW-1:0]            mac_waddr;
  logic                     res_set;
  logic                     res_clr;
  logic                     match;

  assign match = cmp_vld_r && (rd_ip_r == cur_r.ip);
  assign rd_addr = issue_r[IW-1:0];
  assign ip_waddr = count_r[IW-1:0];
  assign mac_waddr = cmp_idx_r;

  // scan sequencer
  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_seen_nxt  = hit_seen_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_ip_nxt    = out_ip_r;
    out_mac_nxt   = out_mac_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    ip_we         = 1'b0;
    mac_we        = 1'b0;
    res_set       = 1'b0;
    res_clr       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_in.vld) begin
          q_pop   = 1'b1;
          cur_nxt = q_in.item;
          case (q_in.item.cls)
            CLS_REPLY_NOW: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REPLY;
              out_ip_nxt    = q_in.item.ip;
              out_mac_nxt   = q_in.item.mac;
            end
            CLS_ARP_REPLY, CLS_LOOKUP: begin
              state_nxt    = ST_SCAN;
              issue_nxt    = '0;
              cmp_vld_nxt  = 1'b0;
              hit_seen_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_NONE;
              out_ip_nxt    = '0;
              out_mac_nxt   = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cur_r.cls == CLS_LOOKUP && match) begin
          // first matching entry ends a lookup
          state_nxt     = ST_IDLE;
          cmp_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_ip_nxt    = cur_r.ip;
          if (resolved_r[cmp_idx_r]) begin
            out_kind_nxt = KIND_HIT;
            out_mac_nxt  = rd_mac_r;
          end else begin
            out_kind_nxt = KIND_PENDING;
            out_mac_nxt  = '0;
          end
        end else begin
          // a received reply updates every matching entry
          if (match) begin
            mac_we       = 1'b1;
            res_set      = 1'b1;
            hit_seen_nxt = 1'b1;
          end
          if (issue_r < count_r) begin
            rd_en       = 1'b1;
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = issue_r[IW-1:0];
            issue_nxt   = issue_r + CW'(1);
          end else if (cmp_vld_r) begin
            cmp_vld_nxt = 1'b0;
          end else begin
            // scan finished with nothing in flight
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            if (cur_r.cls == CLS_ARP_REPLY) begin
              if (hit_seen_r) begin
                out_kind_nxt = KIND_RESOLVED;
                out_ip_nxt   = cur_r.ip;
                out_mac_nxt  = cur_r.mac;
              end else begin
                out_kind_nxt = KIND_NONE;
                out_ip_nxt   = '0;
                out_mac_nxt  = '0;
              end
            end else if (count_r >= FULL_COUNT) begin
              out_kind_nxt = KIND_FULL;
              out_ip_nxt   = cur_r.ip;
              out_mac_nxt  = '0;
            end else begin
              ip_we        = 1'b1;
              res_clr      = 1'b1;
              count_nxt    = count_r + CW'(1);
              out_kind_nxt = KIND_QUERY;
              out_ip_nxt   = cur_r.ip;
              out_mac_nxt  = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= '0;
      cmp_vld_r   <= 1'b0;
      hit_seen_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_seen_r  <= hit_seen_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    cur_r      <= cur_nxt;
    out_kind_r <= out_kind_nxt;
    out_ip_r   <= out_ip_nxt;
    out_mac_r  <= out_mac_nxt;
  end

  // resolved flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolved_r <= '0;
    end else begin
      if (res_set) begin
        resolved_r[mac_waddr] <= 1'b1;
      end
      if (res_clr) begin
        resolved_r[ip_waddr] <= 1'b0;
      end
    end
  end

  // ip memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ip_we) begin
      ip_mem[ip_waddr] <= cur_r.ip;
    end
    if (rd_en) begin
      rd_ip_r <= ip_mem[rd_addr];
    end
  end

  // mac memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_mem[mac_waddr] <= cur_r.mac;
    end
    if (rd_en) begin
      rd_mac_r <= mac_mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_peer_ip     = out_ip_r;
  assign out_peer_mac    = out_mac_r;

endmodule

### sv/arp_cache_responder.sv
// arp_cache_responder: top level of the arp cache and responder
// depends on arpc_pkg, arpc_front and arpc_back
//
//   channel  handshake            payload
//   cfg      cfg_valid/cfg_ready  cfg_data (own ip)
//   in       start, busy          in_opcode .. in_lookup_ip
//   out      out_valid strobe     out_result_kind, out_peer_ip, out_peer_mac
//
// a transaction is taken when start is high and busy is low; a two-entry queue
// sits between the front end and the table engine, so busy rises only when it is full.
// a request, a no-op or an ignored packet is answered from the queue without a table scan;
// a reply or a lookup scans the table one entry per cycle from its single read port;
// a lookup ends at its first matching entry, while a reply always reads every entry.
// synchronous active-low reset clears the queue, the entry count and resolved flags;
// the table memory itself is not cleared. results are not held: out_valid lasts one cycle.
`timescale 1ns / 1ps

module arp_cache_responder
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ARPC_IP_W-1:0]    cfg_data,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_opcode,
  input  logic [ARPC_OPER_W-1:0]  in_arp_operation,
  input  logic [ARPC_IP_W-1:0]    in_sender_ip,
  input  logic [ARPC_MAC_W-1:0]   in_sender_mac,
  input  logic [ARPC_IP_W-1:0]    in_target_ip,
  input  logic [ARPC_IP_W-1:0]    in_lookup_ip,
  output logic                    out_valid,
  output logic [2:0]              out_result_kind,
  output logic [ARPC_IP_W-1:0]    out_peer_ip,
  output logic [ARPC_MAC_W-1:0]   out_peer_mac
);

  arpc_queue_t queue;
  logic        q_pop;

  // accept and classify
  arpc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_arp_operation (in_arp_operation),
    .in_sender_ip     (in_sender_ip),
    .in_sender_mac    (in_sender_mac),
    .in_target_ip     (in_target_ip),
    .in_lookup_ip     (in_lookup_ip),
    .q_out            (queue),
    .q_pop            (q_pop)
  );

  // table engine
  arpc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_in            (queue),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_peer_ip     (out_peer_ip),
    .out_peer_mac    (out_peer_mac)
  );

endmodule
